FILE: rtl/register_mapped_mul_div_unit_defines.svh
// ----------------------------------------------------------------------------
// register_mapped_mul_div_unit_defines.svh
// assertion macros used by the mul/div unit
// ----------------------------------------------------------------------------
`ifndef REGISTER_MAPPED_MUL_DIV_UNIT_DEFINES_SVH
`define REGISTER_MAPPED_MUL_DIV_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge out of reset
`define RMMDU_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rmmdu invariant violated");
// antecedent implies consequent in the same cycle
`define RMMDU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmmdu implication violated");
// antecedent implies consequent in the next cycle
`define RMMDU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmmdu next-cycle check violated");
`else
`define RMMDU_ASSERT_ALWAYS(lbl, cond)
`define RMMDU_ASSERT_IMPL(lbl, ante, cons)
`define RMMDU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/rmmdu_pkg.sv
// ----------------------------------------------------------------------------
// rmmdu_pkg
// widths, register addresses and request codes of the mul/div unit
// ----------------------------------------------------------------------------
package rmmdu_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 2 * BYTE_W;
  localparam int ADDR_W  = 3;
  localparam int NUM_OPND = 6;

  localparam int MUL_STEPS = BYTE_W;
  localparam int DIV_STEPS = WORD_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // request type
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // register addresses
  localparam addr_t ADDR_0 = 3'd0;  // read: product low
  localparam addr_t ADDR_1 = 3'd1;  // read: product high, write: starts multiply
  localparam addr_t ADDR_2 = 3'd2;  // read: remainder low
  localparam addr_t ADDR_3 = 3'd3;  // read: remainder high
  localparam addr_t ADDR_4 = 3'd4;  // read: quotient low
  localparam addr_t ADDR_5 = 3'd5;  // read: quotient high, write: starts divide

  localparam word_t DIV0_QUO = 16'hFFFF;
  localparam word_t DIV0_REM = 16'h0000;

  // status of an arithmetic unit
  typedef struct packed {
    logic  busy;
    word_t lo_word;
    word_t hi_word;
  } unit_stat_t;

endpackage

FILE: rtl/rmmdu_if.sv
// ----------------------------------------------------------------------------
// rmmdu_if
// valid/ready request and response channels of the mul/div unit
// ----------------------------------------------------------------------------
interface rmmdu_req_if;
  import rmmdu_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  addr_t reg_addr;
  byte_t write_byte;

  modport source (output valid, output req_type, output reg_addr, output write_byte,
                  input ready);
  modport sink   (input valid, input req_type, input reg_addr, input write_byte,
                  output ready);
endinterface

interface rmmdu_rsp_if;
  import rmmdu_pkg::*;

  logic  valid;
  logic  ready;
  byte_t read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink   (input valid, input read_byte, output ready);
endinterface

FILE: rtl/rmmdu_mul.sv
// ----------------------------------------------------------------------------
// rmmdu_mul
// bit-serial shift-add 8x8 unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rmmdu_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rmmdu_pkg::byte_t    mcand,
  input  rmmdu_pkg::byte_t    mplier,
  output rmmdu_pkg::unit_stat_t stat
);
  import rmmdu_pkg::*;

  byte_t                mcand_r, mcand_nxt;
  word_t                prod_r, prod_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [BYTE_W:0]      part_sum;

  // upper half accumulates, lower half holds the remaining multiplier bits
  assign part_sum = {1'b0, prod_r[WORD_W-1:BYTE_W]} +
                    {1'b0, (prod_r[0] ? mcand_r : byte_t'(0))};

  always_comb begin
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    if (start) begin
      mcand_nxt = mcand;
      prod_nxt  = {byte_t'(0), mplier};
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      prod_nxt = {part_sum, prod_r[BYTE_W-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      prod_r <= prod_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
  end

  assign stat.busy    = busy_r;
  assign stat.lo_word = prod_r;
  assign stat.hi_word = '0;

endmodule

FILE: rtl/rmmdu_div.sv
// ----------------------------------------------------------------------------
// rmmdu_div
// bit-serial restoring 16/16 unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rmmdu_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  rmmdu_pkg::word_t      dividend,
  input  rmmdu_pkg::word_t      divisor,
  output rmmdu_pkg::unit_stat_t stat
);
  import rmmdu_pkg::*;

  word_t                quo_r, quo_nxt;
  word_t                rem_r, rem_nxt;
  word_t                dsor_r, dsor_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [WORD_W:0]      shifted;
  logic [WORD_W+1:0]    trial;

  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsor_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dsor_nxt = divisor;
      cnt_nxt  = '0;
      if (divisor == '0) begin
        // divide by zero settles at once
        quo_nxt  = DIV0_QUO;
        rem_nxt  = DIV0_REM;
        busy_nxt = 1'b0;
      end else begin
        quo_nxt  = dividend;
        rem_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (trial[WORD_W+1]) begin
        rem_nxt = shifted[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r  <= '0;
      rem_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dsor_r <= dsor_nxt;
  end

  assign stat.busy    = busy_r;
  assign stat.lo_word = rem_r;
  assign stat.hi_word = quo_r;

endmodule

FILE: rtl/register_mapped_mul_div_unit.sv
// ----------------------------------------------------------------------------
// register_mapped_mul_div_unit
// byte-addressed multiply/divide unit: six operand bytes, 8x8 product,
// 16/16 quotient and remainder, readable a byte at a time
// response: each accepted request has its response registered in the cycle after acceptance
// throughput: reads and plain writes 1 request/cycle while the sink takes
//   responses; a write to address 1 holds off new requests for the multiplier
//   bit loop, to address 5 for the divider bit loop, unless the divisor is zero
// reset: synchronous active-low rst_n clears operands, results and control
// ----------------------------------------------------------------------------
`include "register_mapped_mul_div_unit_defines.svh"

module register_mapped_mul_div_unit (
  input logic         clk,
  input logic         rst_n,
  rmmdu_req_if.sink   in_req,
  rmmdu_rsp_if.source out_rsp
);
  import rmmdu_pkg::*;

  byte_t      opnd_r   [NUM_OPND];
  byte_t      opnd_nxt [NUM_OPND];
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_byte_r, out_byte_nxt;

  unit_stat_t mul_stat;
  unit_stat_t div_stat;
  logic       units_busy;
  logic       in_fire;
  logic       is_write;
  logic       mul_start;
  logic       div_start;
  byte_t      rd_byte;

  // a request is taken only while no arithmetic loop is running, so a read
  // after a start always sees finished results; the response register frees
  // itself in the same cycle the sink takes the previous response
  assign units_busy   = mul_stat.busy | div_stat.busy;
  assign in_req.ready = !units_busy && (!out_valid_r || out_rsp.ready);
  assign in_fire      = in_req.valid && in_req.ready;
  assign is_write     = (in_req.req_type == REQ_WRITE);

  // starting writes use the incoming byte for the operand being written
  assign mul_start = in_fire && is_write && (in_req.reg_addr == ADDR_1);
  assign div_start = in_fire && is_write && (in_req.reg_addr == ADDR_5);

  rmmdu_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (opnd_r[0]),
    .mplier (in_req.write_byte),
    .stat   (mul_stat)
  );

  rmmdu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({opnd_r[4], in_req.write_byte}),
    .divisor  ({opnd_r[2], opnd_r[3]}),
    .stat     (div_stat)
  );

  // operand byte file, addresses 6 and 7 are dropped
  always_comb begin
    for (int i = 0; i < NUM_OPND; i++) begin
      opnd_nxt[i] = opnd_r[i];
    end
    if (in_fire && is_write && (in_req.reg_addr < ADDR_W'(NUM_OPND))) begin
      opnd_nxt[in_req.reg_addr] = in_req.write_byte;
    end
  end

  // result byte decoder
  always_comb begin
    unique case (in_req.reg_addr)
      ADDR_0:  rd_byte = mul_stat.lo_word[BYTE_W-1:0];
      ADDR_1:  rd_byte = mul_stat.lo_word[WORD_W-1:BYTE_W];
      ADDR_2:  rd_byte = div_stat.lo_word[BYTE_W-1:0];
      ADDR_3:  rd_byte = div_stat.lo_word[WORD_W-1:BYTE_W];
      ADDR_4:  rd_byte = div_stat.hi_word[BYTE_W-1:0];
      ADDR_5:  rd_byte = div_stat.hi_word[WORD_W-1:BYTE_W];
      default: rd_byte = '0;
    endcase
  end

  // response register: writes answer zero
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = is_write ? byte_t'(0) : rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_OPND; i++) begin
        opnd_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_OPND; i++) begin
        opnd_r[i] <= opnd_nxt[i];
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.read_byte = out_byte_r;

  // checks
  `RMMDU_ASSERT_ALWAYS(a_one_unit_busy, !(mul_stat.busy && div_stat.busy))
  `RMMDU_ASSERT_IMPL(a_no_take_while_busy, in_fire, !units_busy)
  `RMMDU_ASSERT_NEXT(a_mul_runs, mul_start, mul_stat.busy)
  `RMMDU_ASSERT_NEXT(a_rsp_follows, in_fire, out_valid_r)

endmodule
